/* rtl/cfve_pkg.sv */
// Shared types, constants and corner tables for the cube face vertex emitter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cfve_pkg;

  localparam int unsigned ATLAS_TILES_PER_ROW_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF         = 2;
  localparam int unsigned VERTS_PER_FACE          = 6;
  localparam int unsigned VTX_CNT_W               = 3;
  localparam int unsigned TEX_W                   = 11;
  localparam int unsigned TEX_MAX                 = 2047;
  localparam int unsigned TEX_RANGE               = 2048;
  localparam int unsigned TILE_COUNT              = 256;
  localparam int unsigned POS_W                   = 24;
  localparam int unsigned S_DATA_W                = 160;
  localparam int unsigned S_USER_W                = 4;
  localparam int unsigned M_DATA_W                = 120;

  typedef enum logic [2:0] {
    FACE_LEFT   = 3'd0,
    FACE_RIGHT  = 3'd1,
    FACE_TOP    = 3'd2,
    FACE_BOTTOM = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_t;

  // One visible face as it waits between the front and back ends.
  typedef struct packed {
    logic [2:0]              face;
    logic                    flip;
    logic [TEX_W-1:0]        u_lo;
    logic [TEX_W-1:0]        u_hi;
    logic [TEX_W-1:0]        v_lo;
    logic [TEX_W-1:0]        v_hi;
    logic [31:0]             ao;
    logic [31:0]             light;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic [15:0]             half;
  } face_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Saturates an elaboration-time texture coordinate to the 11-bit range.
  function automatic logic [TEX_W-1:0] tex_sat(input int unsigned v);
    logic [TEX_W-1:0] r;
    if (v > TEX_MAX) begin
      r = TEX_W'(TEX_MAX);
    end else begin
      r = TEX_W'(v);
    end
    return r;
  endfunction

  // Corner signs per face, three bits {z, y, x} per corner, corner 0 lowest.
  function automatic logic [2:0] corner_sign(input logic [2:0] face, input logic [1:0] j);
    logic [11:0] row;
    unique case (face_t'(face))
      FACE_LEFT:   row = {3'b110, 3'b010, 3'b100, 3'b000};
      FACE_RIGHT:  row = {3'b111, 3'b011, 3'b101, 3'b001};
      FACE_TOP:    row = {3'b111, 3'b011, 3'b110, 3'b010};
      FACE_BOTTOM: row = {3'b101, 3'b001, 3'b100, 3'b000};
      FACE_FRONT:  row = {3'b011, 3'b001, 3'b010, 3'b000};
      FACE_BACK:   row = {3'b111, 3'b101, 3'b110, 3'b100};
      default:     row = '0;
    endcase
    return row[3*j +: 3];
  endfunction

  // Normal per face as {z, y, x}, two-bit two's complement each.
  function automatic logic [5:0] face_normal(input logic [2:0] face);
    logic [5:0] n;
    unique case (face_t'(face))
      FACE_LEFT:   n = {2'b00, 2'b00, 2'b11};
      FACE_RIGHT:  n = {2'b00, 2'b00, 2'b01};
      FACE_TOP:    n = {2'b00, 2'b01, 2'b00};
      FACE_BOTTOM: n = {2'b00, 2'b11, 2'b00};
      FACE_FRONT:  n = {2'b11, 2'b00, 2'b00};
      FACE_BACK:   n = {2'b01, 2'b00, 2'b00};
      default:     n = '0;
    endcase
    return n;
  endfunction

  // Texture edge per corner as {v, u}; a set bit picks the high edge.
  function automatic logic [1:0] corner_uv(input logic [2:0] face, input logic [1:0] j);
    logic [7:0] row;
    unique case (face_t'(face))
      FACE_LEFT:   row = {2'b11, 2'b10, 2'b01, 2'b00};
      FACE_RIGHT:  row = {2'b10, 2'b11, 2'b00, 2'b01};
      FACE_TOP:    row = {2'b01, 2'b11, 2'b00, 2'b10};
      FACE_BOTTOM: row = {2'b11, 2'b01, 2'b10, 2'b00};
      FACE_FRONT:  row = {2'b11, 2'b01, 2'b10, 2'b00};
      FACE_BACK:   row = {2'b10, 2'b00, 2'b11, 2'b01};
      default:     row = '0;
    endcase
    return row[2*j +: 2];
  endfunction

  // Corner emitted at vertex k, for the face's parity and the split diagonal.
  function automatic logic [1:0] vertex_corner(input logic odd, input logic flip,
                                               input logic [VTX_CNT_W-1:0] k);
    logic [11:0] order;
    unique case ({flip, odd})
      2'b00: order = 12'b11_01_00_10_11_00;
      2'b01: order = 12'b11_10_00_01_11_00;
      2'b10: order = 12'b10_11_01_10_01_00;
      2'b11: order = 12'b01_11_10_01_10_00;
      default: order = '0;
    endcase
    return order[2*k +: 2];
  endfunction

endpackage

`default_nettype wire

/* rtl/cfve_front.sv */
// Front end: classifies each incoming face, drops hidden ones and prepares
// the split diagonal and atlas edges. Depends on cfve_pkg.
`default_nettype none

module cfve_front #(
  parameter int unsigned ATLAS_TILES_PER_ROW = cfve_pkg::ATLAS_TILES_PER_ROW_DEF
) (
  input  logic                           accept,
  input  logic [2:0]                     face_index,
  input  logic                           face_visible,
  input  logic [7:0]                     tile_index,
  input  logic [31:0]                    ao_corners,
  input  logic [31:0]                    light_corners,
  input  logic signed [cfve_pkg::POS_W-1:0] centre_x,
  input  logic signed [cfve_pkg::POS_W-1:0] centre_y,
  input  logic signed [cfve_pkg::POS_W-1:0] centre_z,
  input  logic [15:0]                    half_size,
  output logic                           push,
  output cfve_pkg::face_entry_t          entry
);
  import cfve_pkg::*;

  localparam int unsigned TileSpan = TEX_RANGE / ATLAS_TILES_PER_ROW;

  logic [TEX_W-1:0] u_lo_tbl [TILE_COUNT];
  logic [TEX_W-1:0] u_hi_tbl [TILE_COUNT];
  logic [TEX_W-1:0] v_lo_tbl [TILE_COUNT];
  logic [TEX_W-1:0] v_hi_tbl [TILE_COUNT];
  logic [8:0]       diag_a;
  logic [8:0]       diag_b;

  // Atlas edges for every tile are settled at elaboration.
  for (genvar g = 0; g < TILE_COUNT; g++) begin : g_tex
    localparam int unsigned Col = g % ATLAS_TILES_PER_ROW;
    localparam int unsigned Row = g / ATLAS_TILES_PER_ROW;
    assign u_lo_tbl[g] = tex_sat(Col * TileSpan + 1);
    assign u_hi_tbl[g] = tex_sat(Col * TileSpan + TileSpan - 1);
    assign v_lo_tbl[g] = tex_sat(Row * TileSpan + 1);
    assign v_hi_tbl[g] = tex_sat(Row * TileSpan + TileSpan - 1);
  end

  assign diag_a = {1'b0, ao_corners[7:0]} + {1'b0, ao_corners[31:24]};
  assign diag_b = {1'b0, ao_corners[15:8]} + {1'b0, ao_corners[23:16]};

  assign push = accept && face_visible && (face_index <= 3'(FACE_BACK));

  always_comb begin
    entry.face  = face_index;
    entry.flip  = diag_a > diag_b;
    entry.u_lo  = u_lo_tbl[tile_index];
    entry.u_hi  = u_hi_tbl[tile_index];
    entry.v_lo  = v_lo_tbl[tile_index];
    entry.v_hi  = v_hi_tbl[tile_index];
    entry.ao    = ao_corners;
    entry.light = light_corners;
    entry.cx    = centre_x;
    entry.cy    = centre_y;
    entry.cz    = centre_z;
    entry.half  = half_size;
  end

endmodule

`default_nettype wire

/* rtl/cfve_queue.sv */
// Short register queue of prepared faces between the front and back ends.
// Depends on cfve_pkg.
`default_nettype none

module cfve_queue #(
  parameter int unsigned QUEUE_DEPTH = cfve_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cfve_pkg::face_entry_t wr_entry,
  input  logic                  pop,
  output cfve_pkg::face_entry_t rd_entry,
  output cfve_pkg::q_status_t   status
);
  import cfve_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  face_entry_t     slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign status.full  = count == CntW'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_entry     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cfve_back.sv */
// Back end: walks the six vertices of the face at the queue head and drives
// the registered result stream. Depends on cfve_pkg.
`default_nettype none

module cfve_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  cfve_pkg::face_entry_t               q_entry,
  output logic                                q_pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cfve_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                                m_tlast
);
  import cfve_pkg::*;

  // Centre plus or minus the half size, clamped to the signed 24-bit range.
  function automatic logic [POS_W-1:0] pos_edge(input logic [POS_W-1:0] c,
                                                 input logic [15:0] h,
                                                 input logic plus);
    logic [POS_W:0] s;
    logic [POS_W-1:0] r;
    if (plus) begin
      s = {c[POS_W-1], c} + {9'd0, h};
    end else begin
      s = {c[POS_W-1], c} - {9'd0, h};
    end
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

  logic [VTX_CNT_W-1:0] vtx_cnt;
  logic                 advance;
  logic                 load;
  logic                 is_last;
  logic [1:0]           corner;
  logic [2:0]           sign;
  logic [1:0]           uv_sel;
  logic [M_DATA_W-1:0]  vertex;

  assign advance = !m_tvalid || m_tready;
  assign load    = q_valid && advance;
  assign is_last = vtx_cnt == VTX_CNT_W'(VERTS_PER_FACE - 1);
  assign q_pop   = load && is_last;

  assign corner = vertex_corner(q_entry.face[0], q_entry.flip, vtx_cnt);
  assign sign   = corner_sign(q_entry.face, corner);
  assign uv_sel = corner_uv(q_entry.face, corner);

  always_comb begin
    vertex = {4'd0,
              q_entry.light[8*corner +: 8],
              q_entry.ao[8*corner +: 8],
              uv_sel[1] ? q_entry.v_hi : q_entry.v_lo,
              uv_sel[0] ? q_entry.u_hi : q_entry.u_lo,
              face_normal(q_entry.face),
              pos_edge(q_entry.cz, q_entry.half, sign[2]),
              pos_edge(q_entry.cy, q_entry.half, sign[1]),
              pos_edge(q_entry.cx, q_entry.half, sign[0])};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= q_valid;
      if (q_valid) begin
        vtx_cnt <= is_last ? '0 : vtx_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= vertex;
      m_tlast <= is_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/cube_face_vertex_emitter.sv */
// Cube face vertex emitter: cfve_front, cfve_queue and cfve_back joined; uses cfve_pkg.
// A visible face reaching an empty queue and a free output register is written into the
// queue, then its first vertex is loaded into the output register. Throughput: one vertex
// per cycle while m_tready is high and a face is queued; a hidden face never enters the
// queue. The input stalls only while the queue is full. Reset (rst, synchronous, active
// high) empties the queue and drops m_tvalid; the vertex data register is not reset.
`default_nettype none

module cube_face_vertex_emitter #(
  parameter int unsigned ATLAS_TILES_PER_ROW = cfve_pkg::ATLAS_TILES_PER_ROW_DEF,
  parameter int unsigned QUEUE_DEPTH         = cfve_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tile_index[7:0], ao_corners[39:8], light_corners[71:40], centre_x[95:72],
  // centre_y[119:96], centre_z[143:120], half_size[159:144]
  input  logic [cfve_pkg::S_DATA_W-1:0] s_tdata,
  // face_index[2:0], face_visible[3]
  input  logic [cfve_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], normal_x[73:72], normal_y[75:74],
  // normal_z[77:76], tex_u[88:78], tex_v[99:89], vertex_ao[107:100],
  // vertex_light[115:108], zero fill[119:116]
  output logic [cfve_pkg::M_DATA_W-1:0] m_tdata,
  // last_vertex
  output logic                          m_tlast
);
  import cfve_pkg::*;

  // The front end only ever sees one transaction per cycle and pushes a
  // visible face straight into the queue; the queue's full flag alone holds
  // off the input, so hidden faces pass at full rate until the queue is full.
  // A stalled result stream fills the queue and then holds off every face.
  logic        s_accept;
  logic        push;
  logic        q_pop;
  face_entry_t push_entry;
  face_entry_t head_entry;
  q_status_t   q_stat;

  assign s_tready = !q_stat.full;
  assign s_accept = s_tvalid && s_tready;

  cfve_front #(
    .ATLAS_TILES_PER_ROW(ATLAS_TILES_PER_ROW)
  ) u_front (
    .accept        (s_accept),
    .face_index    (s_tuser[2:0]),
    .face_visible  (s_tuser[3]),
    .tile_index    (s_tdata[7:0]),
    .ao_corners    (s_tdata[39:8]),
    .light_corners (s_tdata[71:40]),
    .centre_x      (s_tdata[95:72]),
    .centre_y      (s_tdata[119:96]),
    .centre_z      (s_tdata[143:120]),
    .half_size     (s_tdata[159:144]),
    .push          (push),
    .entry         (push_entry)
  );

  // Each entry holds one face until the back end has issued its sixth vertex.
  cfve_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (q_pop),
    .rd_entry (head_entry),
    .status   (q_stat)
  );

  // The back end steps through the corner order of the head face, one vertex
  // per transaction, and only advances when its output register is free.
  cfve_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (!q_stat.empty),
    .q_entry  (head_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // A vertex short of the sixth means its face is still held at the queue head.
  a_face_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !q_stat.empty)
    else $error("vertex pending without its face in the queue");

  // A hidden face (visible bit low) accepted into an empty queue leaves it empty.
  a_hidden_dropped: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !s_tuser[3] && q_stat.empty) |=> q_stat.empty)
    else $error("hidden face was queued");

  // The queue is popped only as the final vertex of a face is loaded.
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (m_tvalid && m_tlast))
    else $error("face retired before its last vertex");
`endif

endmodule

`default_nettype wire

/* tb/cube_face_vertex_emitter_tb.sv */
// Self-checking testbench for the cube face vertex emitter: directed table, back pressure, then random faces.
// Holds its own model of the vertex tables; depends on cfve_pkg and the RTL top level only.
`timescale 1ns / 1ps

module cube_face_vertex_emitter_tb;
  import cfve_pkg::*;

  localparam int TILES_PER_ROW  = ATLAS_TILES_PER_ROW_DEF;
  localparam int POS_HI         = 8388607;
  localparam int POS_LO         = -8388608;
  localparam int HALF_MAX       = 65535;
  localparam int RANDOM_FACES   = 200;
  localparam int PRESSURE_FACES = 12;
  localparam int HOLD_CYCLES    = 80;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_NS     = 2_000_000;

  // Face codes outside the six real faces; the block must treat them as hidden.
  localparam logic [2:0] FACE_CODE_SIX   = 3'd6;
  localparam logic [2:0] FACE_CODE_SEVEN = 3'd7;

  // Two-bit normal components.
  localparam logic [1:0] NORM_NONE = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

  typedef enum int {RX_STEADY, RX_BUSY, RX_SPARSE, RX_ALTERNATE} rx_pattern_t;

  // One face as it travels on the input side: {s_tuser, s_tdata}, most significant first.
  typedef struct packed {
    logic                    visible;
    logic [2:0]              face;
    logic [15:0]             half;
    logic signed [POS_W-1:0] cz;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cx;
    logic [31:0]             light;
    logic [31:0]             ao;
    logic [7:0]              tile;
  } face_item_t;

  // One vertex as it leaves the block: {m_tlast, m_tdata[115:0]}.
  typedef struct packed {
    logic                    last;
    logic [7:0]              light;
    logic [7:0]              ao;
    logic [TEX_W-1:0]        v;
    logic [TEX_W-1:0]        u;
    logic [1:0]              nz;
    logic [1:0]              ny;
    logic [1:0]              nx;
    logic signed [POS_W-1:0] pz;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] px;
  } vertex_t;

  typedef struct packed {
    face_item_t item;
    bit         no_vertices;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [S_USER_W-1:0] s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  // Travels alongside each offered face: set when the table says it yields nothing.
  logic                row_no_vertices;

  cube_face_vertex_emitter #(
    .ATLAS_TILES_PER_ROW(TILES_PER_ROW)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  // Corner position signs per face, written as {x, y, z}; a set bit means centre plus half size.
  bit [2:0] corner_xyz [6][4] = '{
    '{3'b000, 3'b001, 3'b010, 3'b011},
    '{3'b100, 3'b101, 3'b110, 3'b111},
    '{3'b010, 3'b011, 3'b110, 3'b111},
    '{3'b000, 3'b001, 3'b100, 3'b101},
    '{3'b000, 3'b010, 3'b100, 3'b110},
    '{3'b001, 3'b011, 3'b101, 3'b111}
  };

  // Texture edge per corner, written as {u, v}; a set bit selects the far edge of the tile.
  bit [1:0] corner_uv_hi [6][4] = '{
    '{2'b00, 2'b10, 2'b01, 2'b11},
    '{2'b10, 2'b00, 2'b11, 2'b01},
    '{2'b01, 2'b00, 2'b11, 2'b10},
    '{2'b00, 2'b01, 2'b10, 2'b11},
    '{2'b00, 2'b01, 2'b10, 2'b11},
    '{2'b10, 2'b11, 2'b00, 2'b01}
  };

  // Triangle corner order, indexed by face parity; the flipped set splits on the other diagonal.
  bit [1:0] tri_plain [2][6] = '{'{0, 3, 2, 0, 1, 3}, '{0, 3, 1, 0, 2, 3}};
  bit [1:0] tri_flip  [2][6] = '{'{0, 1, 2, 1, 3, 2}, '{0, 2, 1, 2, 3, 1}};

  vertex_t expected_vertices [$];

  // Run statistics and failure count.
  int failures        = 0;
  int faces_accepted  = 0;
  int faces_visible   = 0;
  int faces_flipped   = 0;
  int saturated_axes  = 0;
  int vertices_seen   = 0;
  int input_stalls    = 0;

  // Long receiver hold-offs are requested by the stimulus and served by the receiver process.
  int holds_requested = 0;
  int holds_served    = 0;
  int burst_left      = 0;

  // Atlas coordinate of one tile edge, clipped to the 11-bit range.
  function automatic logic [TEX_W-1:0] atlas_coord(input int slot, input bit far_edge);
    int span;
    int coord;
    span  = TEX_RANGE / TILES_PER_ROW;
    coord = slot * span + (far_edge ? span - 1 : 1);
    if (coord > TEX_MAX) coord = TEX_MAX;
    return TEX_W'(coord);
  endfunction

  // Works out the six vertices of a visible face and queues them in emission order.
  function automatic void predict_vertices(input face_item_t it);
    vertex_t vtx;
    int      centre [3];
    int      pos [3];
    int      half;
    int      sum_diag;
    int      sum_anti;
    int      col;
    int      row;
    bit      flip;
    bit      odd;
    bit [1:0] corner;
    if (!it.visible || it.face > FACE_BACK) return;
    faces_visible++;
    centre[0] = it.cx;
    centre[1] = it.cy;
    centre[2] = it.cz;
    half      = int'(it.half);
    // The split flips when the 0-3 diagonal is strictly brighter in occlusion than 1-2.
    sum_diag  = int'(it.ao[7:0]) + int'(it.ao[31:24]);
    sum_anti  = int'(it.ao[15:8]) + int'(it.ao[23:16]);
    flip      = sum_diag > sum_anti;
    odd       = it.face[0];
    col       = int'(it.tile) % TILES_PER_ROW;
    row       = int'(it.tile) / TILES_PER_ROW;
    if (flip) faces_flipped++;
    for (int k = 0; k < VERTS_PER_FACE; k++) begin
      corner = flip ? tri_flip[odd][k] : tri_plain[odd][k];
      for (int ax = 0; ax < 3; ax++) begin
        pos[ax] = corner_xyz[it.face][corner][2 - ax] ? centre[ax] + half : centre[ax] - half;
        if (pos[ax] > POS_HI || pos[ax] < POS_LO) begin
          saturated_axes++;
          pos[ax] = (pos[ax] > POS_HI) ? POS_HI : POS_LO;
        end
      end
      vtx.px = POS_W'(pos[0]);
      vtx.py = POS_W'(pos[1]);
      vtx.pz = POS_W'(pos[2]);
      vtx.nx = NORM_NONE;
      vtx.ny = NORM_NONE;
      vtx.nz = NORM_NONE;
      case (face_t'(it.face))
        FACE_LEFT:   vtx.nx = NORM_NEG;
        FACE_RIGHT:  vtx.nx = NORM_POS;
        FACE_TOP:    vtx.ny = NORM_POS;
        FACE_BOTTOM: vtx.ny = NORM_NEG;
        FACE_FRONT:  vtx.nz = NORM_NEG;
        default:     vtx.nz = NORM_POS;
      endcase
      vtx.u     = atlas_coord(col, corner_uv_hi[it.face][corner][1]);
      vtx.v     = atlas_coord(row, corner_uv_hi[it.face][corner][0]);
      vtx.ao    = it.ao[8*corner +: 8];
      vtx.light = it.light[8*corner +: 8];
      vtx.last  = (k == VERTS_PER_FACE - 1);
      expected_vertices.push_back(vtx);
    end
  endfunction

  function automatic string vertex_str(input vertex_t v);
    return $sformatf("pos=(%0d,%0d,%0d) n=(%0d,%0d,%0d) uv=(%0d,%0d) ao=%0d light=%0d last=%0b",
                     v.px, v.py, v.pz, $signed(v.nx), $signed(v.ny), $signed(v.nz),
                     v.u, v.v, v.ao, v.light, v.last);
  endfunction

  function automatic stim_row_t dir_row(input logic [2:0] face, input bit visible,
                                        input logic [7:0] tile, input logic [31:0] ao,
                                        input logic [31:0] light, input int cx, input int cy,
                                        input int cz, input int half, input bit no_vertices);
    stim_row_t r;
    r.item.face       = face;
    r.item.visible    = visible;
    r.item.tile       = tile;
    r.item.ao         = ao;
    r.item.light      = light;
    r.item.cx         = POS_W'(cx);
    r.item.cy         = POS_W'(cy);
    r.item.cz         = POS_W'(cz);
    r.item.half       = 16'(half);
    r.no_vertices     = no_vertices;
    return r;
  endfunction

  // Centre coordinate that lands near either end of the range often enough to saturate.
  function automatic logic signed [POS_W-1:0] random_centre();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return POS_W'(POS_HI - int'($urandom_range(0, 70000)));
    if (pick < 30) return POS_W'(POS_LO + int'($urandom_range(0, 70000)));
    return POS_W'($urandom);
  endfunction

  function automatic face_item_t random_face();
    face_item_t it;
    int         a0;
    int         a1;
    int         a2;
    int         a3;
    int         pick;
    // Now and then a face code beyond the six real faces.
    it.face    = ($urandom_range(0, 99) < 4) ? ($urandom_range(0, 1) ? FACE_CODE_SIX
                                                                     : FACE_CODE_SEVEN)
                                              : 3'($urandom_range(FACE_LEFT, FACE_BACK));
    it.visible = ($urandom_range(0, 99) < 88);
    it.tile    = 8'($urandom);
    it.light   = $urandom;
    it.ao      = $urandom;
    // A fifth of the faces sit on or next to the diagonal tie.
    if ($urandom_range(0, 4) == 0) begin
      a0 = $urandom_range(0, 255);
      a1 = $urandom_range(0, 255);
      a2 = $urandom_range(0, 255);
      a3 = a1 + a2 - a0 + int'($urandom_range(0, 2)) - 1;
      if (a3 < 0) a3 = 0;
      if (a3 > 255) a3 = 255;
      it.ao = {8'(a3), 8'(a2), 8'(a1), 8'(a0)};
    end
    it.cx = random_centre();
    it.cy = random_centre();
    it.cz = random_centre();
    pick  = $urandom_range(0, 9);
    it.half = (pick == 0) ? 16'(HALF_MAX) : (pick == 1) ? 16'd0 : 16'($urandom);
    return it;
  endfunction

  // Offers one face and returns once the transaction has completed.
  task automatic offer(input face_item_t it, input bit no_vertices);
    @(negedge clk);
    s_tvalid           <= 1'b1;
    {s_tuser, s_tdata} <= it;
    row_no_vertices    <= no_vertices;
    do @(posedge clk); while (!s_tready);
  endtask

  // Lowers valid for a number of cycles, with junk on the data lines meanwhile.
  task automatic idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= {5{$urandom}};
      s_tuser  <= 4'($urandom);
    end
  endtask

  // Bursty sender: bursts of random length separated by random gaps.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
  endtask

  // Receiver: long hold-offs when asked, otherwise a stall pattern that changes now and then.
  always @(negedge clk) begin : receiver
    static int          hold_left = 0;
    static int          mode_left = 0;
    static rx_pattern_t rx_mode   = RX_STEADY;
    if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_pattern_t'($urandom_range(RX_STEADY, RX_ALTERNATE));
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_BUSY:   m_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  // Scoreboard: faces are predicted as their transaction completes, vertices are checked
  // in order against the oldest expectation.
  always @(posedge clk) begin : scoreboard
    face_item_t accepted;
    vertex_t    got;
    vertex_t    want;
    if (!rst) begin
      if (s_tvalid && !s_tready) input_stalls++;
      if (s_tvalid && s_tready) begin
        faces_accepted++;
        accepted = face_item_t'({s_tuser, s_tdata});
        // Rows typed as yielding nothing queue no expectation at all.
        if (!row_no_vertices) predict_vertices(accepted);
      end
      if (m_tvalid && m_tready) begin
        vertices_seen++;
        got = vertex_t'({m_tlast, m_tdata[115:0]});
        if (expected_vertices.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("[%0t] unexpected vertex: %s", $realtime, vertex_str(got));
        end else begin
          want = expected_vertices.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("[%0t] vertex mismatch", $realtime);
              $display("  expected %s", vertex_str(want));
              $display("  actual   %s", vertex_str(got));
            end
          end
        end
      end
    end
  end

  // Watchdog: a run that hangs ends here.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t  directed_tab [$];
    face_item_t it;

    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tuser         = '0;
    row_no_vertices = 1'b0;

    // Each face twice, once per split diagonal, then hidden faces and the extremes.
    directed_tab = '{
      dir_row(FACE_LEFT,   1, 8'h00, 32'h0000_8000, 32'h0403_0201, 256, -512, 1024, 128, 0),
      dir_row(FACE_LEFT,   1, 8'h11, 32'h0000_0080, 32'h1122_3344, -256, 512, 0, 384, 0),
      dir_row(FACE_RIGHT,  1, 8'h23, 32'h0000_8000, 32'h5566_7788, 1000, 2000, 3000, 64, 0),
      dir_row(FACE_RIGHT,  1, 8'h34, 32'h8000_0000, 32'h99aa_bbcc, -1000, -2000, -3000, 640, 0),
      dir_row(FACE_TOP,    1, 8'h45, 32'h0080_0000, 32'hddee_ff00, 4096, 0, -4096, 256, 0),
      dir_row(FACE_TOP,    1, 8'h56, 32'h2000_0030, 32'h0102_0408, 0, 4096, 0, 512, 0),
      dir_row(FACE_BOTTOM, 1, 8'h67, 32'h0000_4000, 32'h1020_4080, 77, -77, 7, 1, 0),
      dir_row(FACE_BOTTOM, 1, 8'h78, 32'h0100_0001, 32'h8040_2010, -9, 9, -99, 999, 0),
      dir_row(FACE_FRONT,  1, 8'h89, 32'h0010_1000, 32'h3c3c_c3c3, 500, 600, 700, 300, 0),
      dir_row(FACE_FRONT,  1, 8'h9a, 32'h7f00_007f, 32'hc3c3_3c3c, -500, -600, -700, 300, 0),
      dir_row(FACE_BACK,   1, 8'hab, 32'h00ff_0000, 32'h0f0f_f0f0, 12345, -54321, 0, 4000, 0),
      dir_row(FACE_BACK,   1, 8'hbc, 32'hff00_0000, 32'hf0f0_0f0f, -12345, 54321, 1, 4000, 0),
      // A hidden face, and the two codes past the last face, yield nothing.
      dir_row(FACE_TOP,        0, 8'hcd, 32'h1234_5678, 32'h8765_4321, 0, 0, 0, 256, 1),
      dir_row(FACE_CODE_SIX,   1, 8'hde, 32'h0000_0080, 32'hffff_ffff, 0, 0, 0, 256, 1),
      dir_row(FACE_CODE_SEVEN, 1, 8'hef, 32'h0000_8000, 32'hffff_ffff, 0, 0, 0, 256, 1),
      // Largest centre and half size: the plus side saturates high; occlusion tie.
      dir_row(FACE_RIGHT, 1, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
              POS_HI, POS_HI, POS_HI, HALF_MAX, 0),
      // Smallest centre: the minus side saturates low; the diagonal sum needs nine bits.
      dir_row(FACE_LEFT, 1, 8'hf0, 32'hff00_00ff, 32'h0000_0000,
              POS_LO, POS_LO, POS_LO, HALF_MAX, 0),
      // Zero half size collapses every corner onto the centre.
      dir_row(FACE_FRONT, 1, 8'h0f, 32'h00ff_ff00, 32'ha5a5_a5a5, 123456, -123456, 77, 0, 0),
      // Diagonal sums one apart either way, positions landing exactly on the range ends.
      dir_row(FACE_BACK, 1, 8'h5a, 32'h8080_8081, 32'h5a5a_5a5a,
              POS_HI - HALF_MAX, POS_LO + HALF_MAX, 0, HALF_MAX, 0),
      dir_row(FACE_BOTTOM, 1, 8'ha5, 32'h8080_8180, 32'h0123_4567,
              POS_LO + HALF_MAX, POS_HI - HALF_MAX, -1, HALF_MAX, 0)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_tab[i]) begin
      offer(directed_tab[i].item, directed_tab[i].no_vertices);
      pace();
    end
    idle(1);
    wait_drained();

    // Back pressure: the receiver holds off while faces keep coming, so the queue fills
    // and the input side has to stall.
    holds_requested++;
    repeat (PRESSURE_FACES) begin
      it         = random_face();
      it.visible = 1'b1;
      it.face    = 3'($urandom_range(FACE_LEFT, FACE_BACK));
      offer(it, 1'b0);
    end
    idle(1);
    wait_drained();

    for (int n = 0; n < RANDOM_FACES; n++) begin
      if (n == RANDOM_FACES / 2) holds_requested++;
      offer(random_face(), 1'b0);
      pace();
    end
    idle(1);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d faces (%0d visible, %0d with the split flipped), %0d vertices,",
             faces_accepted, faces_visible, faces_flipped, vertices_seen);
    $display("%0d saturated axis values, %0d input stall cycles and %0d failures.",
             saturated_axes, input_stalls, failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cfve_pkg.sv
rtl/cfve_front.sv
rtl/cfve_queue.sv
rtl/cfve_back.sv
rtl/cube_face_vertex_emitter.sv
tb/cube_face_vertex_emitter_tb.sv
